### sv/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 11;
  localparam int ROW_W     = 16;
  localparam int LUMA_W    = 24;
  localparam int PIX_W     = 8;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [LUMA_W-1:0]     luma_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes on the configuration channel
  localparam cfg_addr_t CFG_IMAGE_WIDTH  = 8'd0;
  localparam cfg_addr_t CFG_IMAGE_HEIGHT = 8'd1;

  localparam col_t RESET_WIDTH  = 11'd640;
  localparam row_t RESET_HEIGHT = 16'd480;
  localparam col_t MIN_WIDTH    = 11'd3;
  localparam row_t MIN_HEIGHT   = 16'd3;

  // luma weights, 0.299 / 0.587 / 0.114 in Q16
  localparam luma_t WEIGHT_R = 24'd19595;
  localparam luma_t WEIGHT_G = 24'd38470;
  localparam luma_t WEIGHT_B = 24'd7471;

endpackage

`default_nettype wire

### sv/sem_ifs.sv
`default_nettype none

interface sem_pix_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface sem_mag_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  pix_t magnitude;
  logic frame_last;

  modport source (output valid, output magnitude, output frame_last, input ready);
  modport sink   (input valid, input magnitude, input frame_last, output ready);
endinterface

interface sem_cfg_if import sem_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### sv/sobel_edge_magnitude.sv
`default_nettype none

// Sobel 3x3 gradient magnitude over a raster-order RGB stream. Each pixel is
// converted to Q16 luma and read-modify-written into two 1024-entry line
// stores (synchronous read), which feed a 3x3 window. One word leaves for
// every interior centre pixel: floor(sqrt(gx^2+gy^2)) saturated at 255, with
// frame_last set on the last interior pixel of the frame; border pixels give
// no word. Pixels are handled one at a time: a border pixel passes through
// accept and line store write-back, an interior pixel through accept,
// write-back, gradient, squaring, 8 square-root steps and hand-off, the root
// unit resolving one result bit per cycle. The output register lets the next
// pixel enter while a result waits. Writing either register restarts the
// frame position; line stores need no clearing after reset.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sem_pix_if.sink   in_pix,
  sem_mag_if.source out_mag,
  sem_cfg_if.sink   cfg_wr
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LUMA = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int GRAD_W = LUMA_W + 2;
  localparam int SQ_W   = 2 * GRAD_W + 1;
  localparam int Q_W    = SQ_W - 32;

  logic [2:0] state_r, state_nxt;

  col_t width_r, w_eff;
  row_t height_r, h_eff;
  col_t col_r;
  row_t row_r;

  logic [ADDR_W-1:0] addr_r;
  pix_t  red_r, green_r, blue_r;
  logic  is_out_r, is_last_r;
  luma_t top_rd_r, mid_rd_r;
  luma_t luma;
  luma_t win_r [9];

  luma_t upper_mem  [MAX_WIDTH];
  luma_t middle_mem [MAX_WIDTH];

  logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg, ax, ay;
  logic [GRAD_W-1:0] ax_r, ay_r;
  logic [SQ_W-1:0]   sq_sum;
  logic [Q_W-1:0]    q_r;
  pix_t              m_r, trial;
  logic [2:0]        bit_r;
  logic [2*PIX_W-1:0] trial_sq;

  logic out_valid_r;
  pix_t mag_out_r;
  logic last_out_r;

  logic in_acc, cfg_acc, cfg_hit, load_out;
  col_t c_inc;
  logic [ROW_W:0] r_inc;

  assign in_pix.ready = (state_r == S_IDLE);
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;
  assign cfg_hit      = cfg_acc &&
                        (cfg_wr.addr == CFG_IMAGE_WIDTH || cfg_wr.addr == CFG_IMAGE_HEIGHT);

  always_comb begin
    w_eff = width_r;
    if (width_r < MIN_WIDTH) w_eff = MIN_WIDTH;
    else if (width_r > COL_W'(MAX_WIDTH)) w_eff = COL_W'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r < MIN_HEIGHT) h_eff = MIN_HEIGHT;
  end

  // configuration and frame position
  assign c_inc = col_r + 1'b1;
  assign r_inc = {1'b0, row_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_hit) begin
      if (cfg_wr.addr == CFG_IMAGE_WIDTH) width_r <= cfg_wr.data[COL_W-1:0];
      else height_r <= cfg_wr.data[ROW_W-1:0];
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (c_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_r <= c_inc;
      end
    end
  end

  // item capture at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r    <= col_r[ADDR_W-1:0];
      red_r     <= in_pix.red;
      green_r   <= in_pix.green;
      blue_r    <= in_pix.blue;
      is_out_r  <= (row_r >= 16'd2) && (col_r >= 11'd2);
      is_last_r <= (row_r == h_eff - 1'b1) && (col_r == w_eff - 1'b1);
    end
  end

  // line stores: read at accept, written back in the cycle after (S_LUMA)
  always_ff @(posedge clk) begin
    if (in_acc) top_rd_r <= upper_mem[col_r[ADDR_W-1:0]];
    if (state_r == S_LUMA) upper_mem[addr_r] <= mid_rd_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) mid_rd_r <= middle_mem[col_r[ADDR_W-1:0]];
    if (state_r == S_LUMA) middle_mem[addr_r] <= luma;
  end

  assign luma = WEIGHT_R * {16'b0, red_r} + WEIGHT_G * {16'b0, green_r}
              + WEIGHT_B * {16'b0, blue_r};

  always_ff @(posedge clk) begin
    if (state_r == S_LUMA) begin
      for (int r = 0; r < 3; r++) begin
        win_r[3*r]   <= win_r[3*r+1];
        win_r[3*r+1] <= win_r[3*r+2];
      end
      win_r[2] <= top_rd_r;
      win_r[5] <= mid_rd_r;
      win_r[8] <= luma;
    end
  end

  // gradients as differences of two non-negative sums
  assign gx_pos = GRAD_W'(win_r[2]) + GRAD_W'({win_r[5], 1'b0}) + GRAD_W'(win_r[8]);
  assign gx_neg = GRAD_W'(win_r[0]) + GRAD_W'({win_r[3], 1'b0}) + GRAD_W'(win_r[6]);
  assign gy_pos = GRAD_W'(win_r[6]) + GRAD_W'({win_r[7], 1'b0}) + GRAD_W'(win_r[8]);
  assign gy_neg = GRAD_W'(win_r[0]) + GRAD_W'({win_r[1], 1'b0}) + GRAD_W'(win_r[2]);
  assign ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
  assign ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;

  assign sq_sum = SQ_W'(ax_r * ax_r) + SQ_W'(ay_r * ay_r);

  // m^2 * 2^32 <= s  is  m^2 <= s >> 32
  assign trial    = m_r | (PIX_W'(1) << bit_r);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    case (state_r)
      S_GRAD: begin
        ax_r <= ax;
        ay_r <= ay;
      end
      S_SQ: begin
        q_r   <= sq_sum[SQ_W-1:32];
        m_r   <= '0;
        bit_r <= 3'd7;
      end
      S_ROOT: begin
        if (Q_W'(trial_sq) <= q_r) m_r <= trial;
        bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LUMA;
      S_LUMA: state_nxt = is_out_r ? S_GRAD : S_IDLE;
      S_GRAD: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ROOT;
      S_ROOT: if (bit_r == 3'd0) state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // output register
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_mag.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_mag.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mag_out_r  <= m_r;
      last_out_r <= is_last_r;
    end
  end

  assign out_mag.valid      = out_valid_r;
  assign out_mag.magnitude  = mag_out_r;
  assign out_mag.frame_last = last_out_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LUMA) && !in_pix.ready)
    else $error("pixel accepted while another is in work");

  a_border_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LUMA) && !is_out_r |=> (state_r == S_IDLE) && !$rose(out_valid_r))
    else $error("border pixel produced a result");

  a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < w_eff) && (row_r < h_eff))
    else $error("frame position outside the frame");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (Q_W'(m_r * m_r) <= q_r))
    else $error("partial root exceeds the scaled sum");

  a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word appeared outside hand-off");

endmodule

`default_nettype wire

### dv/sobel_edge_magnitude_test.sv
`default_nettype none

module sobel_edge_magnitude_test;
  import sem_pkg::*;

  localparam int LIMIT          = 1_000_000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int SHOWN_ERRORS   = 10;
  localparam int RANDOM_PIXELS  = 750;
  localparam int RANDOM_RESULTS = 100;

  localparam pix_t LO = 8'd0;
  localparam pix_t MD = 8'd128;
  localparam pix_t HI = 8'd255;

  typedef struct packed {
    pix_t magnitude;
    logic frame_last;
  } mag_word_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic typed;
    pix_t magnitude;
    logic frame_last;
  } probe_row_t;

  typedef enum int {NOISE, SOFT_NOISE, FLAT, RAMP} texture_t;

  logic clk;
  logic rst_n;

  sem_pix_if pix_ch ();
  sem_mag_if mag_ch ();
  sem_cfg_if cfg_ch ();

  sobel_edge_magnitude DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch.sink),
    .out_mag (mag_ch.source),
    .cfg_wr  (cfg_ch.sink)
  );

  // three 3x3 frames: horizontal edge, vertical edge, single-channel mix
  probe_row_t probe_rows [27] = '{
    '{LO, LO, LO, 1'b0, LO, 1'b0}, '{MD, MD, MD, 1'b0, LO, 1'b0}, '{HI, HI, HI, 1'b0, LO, 1'b0},
    '{LO, LO, LO, 1'b0, LO, 1'b0}, '{MD, MD, MD, 1'b0, LO, 1'b0}, '{HI, HI, HI, 1'b0, LO, 1'b0},
    '{LO, LO, LO, 1'b0, LO, 1'b0}, '{MD, MD, MD, 1'b0, LO, 1'b0}, '{HI, HI, HI, 1'b1, HI, 1'b1},
    '{LO, LO, LO, 1'b0, LO, 1'b0}, '{LO, LO, LO, 1'b0, LO, 1'b0}, '{LO, LO, LO, 1'b0, LO, 1'b0},
    '{LO, HI, LO, 1'b0, LO, 1'b0}, '{LO, HI, LO, 1'b0, LO, 1'b0}, '{LO, HI, LO, 1'b0, LO, 1'b0},
    '{HI, HI, HI, 1'b0, LO, 1'b0}, '{HI, HI, HI, 1'b0, LO, 1'b0}, '{HI, HI, HI, 1'b1, HI, 1'b1},
    '{8'd10, LO, LO, 1'b0, LO, 1'b0}, '{LO, 8'd10, LO, 1'b0, LO, 1'b0},
    '{LO, LO, 8'd10, 1'b0, LO, 1'b0},
    '{HI, LO, LO, 1'b0, LO, 1'b0}, '{LO, HI, LO, 1'b0, LO, 1'b0}, '{LO, LO, HI, 1'b0, LO, 1'b0},
    '{8'd20, LO, LO, 1'b0, LO, 1'b0}, '{LO, 8'd20, LO, 1'b0, LO, 1'b0},
    '{LO, LO, 8'd40, 1'b0, LO, 1'b0}
  };

  // gradient predictor state
  luma_t       upper_line [MAX_WIDTH];
  luma_t       middle_line [MAX_WIDTH];
  luma_t       win [9];
  int unsigned col_pos;
  int unsigned row_pos;
  col_t        width_reg;
  row_t        height_reg;

  mag_word_t   mag_queue [$];
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          steady_phase = 0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned eff_width();
    if (width_reg < MIN_WIDTH) return 32'(MIN_WIDTH);
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_HEIGHT) return 32'(MIN_HEIGHT);
    return 32'(height_reg);
  endfunction

  // largest m with (m * 2^16)^2 <= energy, one bit at a time
  function automatic pix_t root_of(longint unsigned energy);
    pix_t m;
    longint unsigned trial;
    m = '0;
    for (int k = PIX_W - 1; k >= 0; k--) begin
      trial = 64'(m | pix_t'(1 << k)) << 16;
      if (trial * trial <= energy) m = m | pix_t'(1 << k);
    end
    return m;
  endfunction

  function automatic bit predict_pixel(input pix_t r, input pix_t g, input pix_t b,
                                       output mag_word_t word);
    int unsigned w;
    int unsigned h;
    luma_t y;
    luma_t above;
    luma_t centre;
    longint gx;
    longint gy;
    bit hit;
    w = eff_width();
    h = eff_height();
    y = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
    above = upper_line[col_pos];
    centre = middle_line[col_pos];
    upper_line[col_pos] = centre;
    middle_line[col_pos] = y;
    for (int i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = above;
    win[5] = centre;
    win[8] = y;
    word = '0;
    hit = 1'b0;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (longint'(win[2]) + 2 * longint'(win[5]) + longint'(win[8]))
         - (longint'(win[0]) + 2 * longint'(win[3]) + longint'(win[6]));
      gy = (longint'(win[6]) + 2 * longint'(win[7]) + longint'(win[8]))
         - (longint'(win[0]) + 2 * longint'(win[1]) + longint'(win[2]));
      word.magnitude = root_of(longint'(gx * gx + gy * gy));
      word.frame_last = (row_pos == h - 1 && col_pos == w - 1);
      hit = 1'b1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  // leaves valid high so back-to-back writes run without a gap
  task automatic write_reg(cfg_addr_t idx, cfg_data_t value);
    bit took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do begin
      @(negedge clk);
      took = (cfg_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = value[COL_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = value;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic configure(bit do_w, cfg_data_t w_val, bit do_h, cfg_data_t h_val,
                           bit h_first);
    if (do_h && h_first) write_reg(CFG_IMAGE_HEIGHT, h_val);
    if (do_w) write_reg(CFG_IMAGE_WIDTH, w_val);
    if (do_h && !h_first) write_reg(CFG_IMAGE_HEIGHT, h_val);
    cfg_ch.valid <= 1'b0;
  endtask

  // bursts of words with random gaps; valid stays high inside a burst
  task automatic offer_pixel(pix_t r, pix_t g, pix_t b);
    int gap;
    bit took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_phase || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    do begin
      @(negedge clk);
      took = (pix_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
  endtask

  task automatic feed_pixels(int count, texture_t tex);
    pix_t base_r;
    pix_t base_g;
    pix_t base_b;
    pix_t r;
    pix_t g;
    pix_t b;
    mag_word_t word;
    base_r = pix_t'($urandom_range(0, 248));
    base_g = pix_t'($urandom_range(0, 248));
    base_b = pix_t'($urandom_range(0, 248));
    for (int n = 0; n < count; n++) begin
      case (tex)
        NOISE: begin
          r = pix_t'($urandom);
          g = pix_t'($urandom);
          b = pix_t'($urandom);
        end
        SOFT_NOISE: begin
          r = base_r + pix_t'($urandom_range(0, 7));
          g = base_g + pix_t'($urandom_range(0, 7));
          b = base_b + pix_t'($urandom_range(0, 7));
        end
        FLAT: begin
          r = base_r;
          g = base_g;
          b = base_b;
        end
        default: begin
          r = base_r + pix_t'(n % 8);
          g = base_g;
          b = base_b + pix_t'((n / 8) % 8);
        end
      endcase
      offer_pixel(r, g, b);
      if (predict_pixel(r, g, b, word)) mag_queue.push_back(word);
    end
    pix_ch.valid <= 1'b0;
  endtask

  // border pixels may still be in flight once the last result is out
  task automatic wait_drained();
    while (mag_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checker, sampled away from the driving edge
  always @(negedge clk) begin
    mag_word_t want;
    if (rst_n === 1'b1 && mag_ch.valid === 1'b1 && mag_ch.ready === 1'b1) begin
      results_seen++;
      if (mag_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected word: magnitude %0d frame_last %0b",
                   mag_ch.magnitude, mag_ch.frame_last);
      end else begin
        want = mag_queue.pop_front();
        if (mag_ch.magnitude !== want.magnitude || mag_ch.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("mismatch: expected magnitude %0d frame_last %0b, got %0d %0b",
                     want.magnitude, want.frame_last, mag_ch.magnitude, mag_ch.frame_last);
        end
      end
    end
  end

  // receiver: shifting stall patterns, plus one long hold to back up the pipe
  initial begin : receiver
    int tick;
    int mode;
    bit held_long;
    tick = 0;
    mode = 0;
    held_long = 0;
    mag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held_long && results_seen >= 40) begin
        held_long = 1;
        mag_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (tick % 97 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: mag_ch.ready <= 1'b1;
          1: mag_ch.ready <= ($urandom_range(0, 3) != 0);
          2: mag_ch.ready <= ($urandom_range(0, 3) == 0);
          default: mag_ch.ready <= tick[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    mag_word_t word;
    int items_random;
    int phase_no;
    int total;
    int half;
    bit both;
    bit pick_w;
    cfg_data_t w_data;
    cfg_data_t h_data;
    int unsigned sel;

    rst_n        <= 1'b0;
    pix_ch.valid <= 1'b0;
    pix_ch.red   <= '0;
    pix_ch.green <= '0;
    pix_ch.blue  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= '0;
    cfg_ch.data  <= '0;
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    foreach (win[i]) win[i] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, just past the first two rows
    feed_pixels(2 * RESET_WIDTH + 8, SOFT_NOISE);
    wait_drained();

    configure(1'b1, 16'd3, 1'b1, 16'd3, 1'b0);
    foreach (probe_rows[i]) begin
      offer_pixel(probe_rows[i].red, probe_rows[i].green, probe_rows[i].blue);
      if (predict_pixel(probe_rows[i].red, probe_rows[i].green, probe_rows[i].blue, word))
        mag_queue.push_back(probe_rows[i].typed
                            ? mag_word_t'{probe_rows[i].magnitude, probe_rows[i].frame_last}
                            : word);
    end
    pix_ch.valid <= 1'b0;
    wait_drained();

    // tallest frame, narrowest row
    configure(1'b1, 16'd3, 1'b1, 16'hFFFF, 1'b1);
    feed_pixels(30, NOISE);
    wait_drained();

    // all ones in the width word clamps to the widest row
    configure(1'b1, 16'hFFFF, 1'b1, 16'd3, 1'b0);
    feed_pixels(2 * MAX_WIDTH + 10, NOISE);
    wait_drained();

    items_random = 0;
    phase_no = 0;
    while (items_random < RANDOM_PIXELS || results_seen < RANDOM_RESULTS) begin
      phase_no++;
      sel = $urandom_range(0, 9);
      w_data = cfg_data_t'($urandom_range(3, 12));
      h_data = cfg_data_t'($urandom_range(3, 8));
      if (sel == 0) w_data = cfg_data_t'($urandom_range(0, 2));
      if (sel == 1) h_data = cfg_data_t'($urandom_range(0, 2));
      if (sel == 2) w_data = w_data | (cfg_data_t'($urandom_range(1, 31)) << COL_W);
      both = ($urandom_range(0, 4) != 0);
      pick_w = both || ($urandom_range(0, 1) == 1);
      configure(pick_w, w_data, both || !pick_w, h_data, $urandom_range(0, 1) == 1);

      total = $urandom_range(1, 3) * eff_width() * eff_height();
      // sometimes cut the frame short and restart with the next write
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      steady_phase = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        half = total / 2;
        feed_pixels(half, texture_t'($urandom_range(0, 3)));
        wait_drained();
        feed_pixels(total - half, texture_t'($urandom_range(0, 3)));
      end else begin
        feed_pixels(total, texture_t'($urandom_range(0, 3)));
      end
      items_random += total;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/sem_pkg.sv
sv/sem_ifs.sv
sv/sobel_edge_magnitude.sv
dv/sobel_edge_magnitude_test.sv
